@@ rtl/utf8e_pkg.sv @@
`timescale 1ns / 1ps

package utf8e_pkg;

    localparam logic [7:0] HIGH_BIT   = 8'h80;
    localparam logic [7:0] ESC_CHAR   = 8'h5C;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;

    // Position inside a four-byte escape: backslash, then three octal digits.
    localparam logic [1:0] DIG_BSL = 2'd0;
    localparam logic [1:0] DIG_HI  = 2'd1;
    localparam logic [1:0] DIG_MID = 2'd2;
    localparam logic [1:0] DIG_LO  = 2'd3;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic pending;
        logic final_byte;
        logic out_free;
    } status_t;

    // Sequence length for a lead byte; 0 when the byte cannot lead.
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if (b >= 8'hC2 && b <= 8'hDF) len = 3'd2;
        else if (b >= 8'hE0 && b <= 8'hEF) len = 3'd3;
        else if (b >= 8'hF0 && b <= 8'hF4) len = 3'd4;
        return len;
    endfunction

    // Allowed range of the second byte depends on the lead byte.
    function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = CONT_LO;
        hi = CONT_HI;
        if (lead == 8'hE0) lo = 8'hA0;
        else if (lead == 8'hED) hi = 8'h9F;
        else if (lead == 8'hF0) lo = 8'h90;
        else if (lead == 8'hF4) hi = 8'h8F;
        return (b >= lo) && (b <= hi);
    endfunction

endpackage

@@ rtl/utf8e_ctrl.sv @@
`timescale 1ns / 1ps

module utf8e_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  utf8e_pkg::status_t  status,
    output utf8e_pkg::cmd_t     cmd
);

    utf8e_pkg::state_t state_reg;
    utf8e_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= utf8e_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            utf8e_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = utf8e_pkg::ST_EMIT;
                end
            end
            utf8e_pkg::ST_EMIT:
            begin
                if (!status.pending ||
                    (status.out_free && status.final_byte))
                begin
                    state_next = utf8e_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = utf8e_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            utf8e_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            utf8e_pkg::ST_EMIT:
            begin
                cmd.emit = status.pending && status.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

@@ rtl/utf8e_dp.sv @@
`timescale 1ns / 1ps

module utf8e_dp
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  logic                end_of_text,
    input  utf8e_pkg::cmd_t     cmd,
    output utf8e_pkg::status_t  status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_char,
    output logic                run_last,
    output logic                text_last
);

    // Decoder state
    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] cnt_reg, cnt_next;
    logic [2:0] exp_reg, exp_next;

    // Emission plan: slots 0..2 are held bytes, slot 3 is the new byte
    logic [7:0] slot_byte_reg [4];
    logic [3:0] slot_vld_reg, slot_vld_next;
    logic [3:0] slot_esc_reg;
    logic [1:0] digit_reg, digit_next;
    logic       last_reg;

    logic [7:0] out_char_reg;
    logic       out_valid_reg, run_last_reg, text_last_reg;

    // Plan built at load
    logic [3:0] plan_vld, plan_esc;
    logic       cont_ok, complete, fresh;
    logic [2:0] len_b;

    always_comb
    begin
        held_next = held_reg;
        cnt_next  = cnt_reg;
        exp_next  = exp_reg;
        plan_vld  = 4'b0;
        plan_esc  = 4'b0;
        fresh     = 1'b0;
        len_b     = utf8e_pkg::lead_len(data_byte);
        if (cnt_reg == 2'd1)
        begin
            cont_ok = utf8e_pkg::second_ok(held_reg[0], data_byte);
        end
        else
        begin
            cont_ok = (data_byte >= utf8e_pkg::CONT_LO) && (data_byte <= utf8e_pkg::CONT_HI);
        end
        complete = (({1'b0, cnt_reg} + 3'd1) >= exp_reg);

        if (cnt_reg == 2'd0)
        begin
            fresh = 1'b1;
        end
        else if (!cont_ok)
        begin
            // bad continuation: escape everything held, restart on the new byte
            for (int i = 0; i < 3; i++)
            begin
                plan_vld[i] = (2'(i) < cnt_reg);
                plan_esc[i] = 1'b1;
            end
            cnt_next = 2'd0;
            exp_next = 3'd0;
            fresh    = 1'b1;
        end
        else if (complete)
        begin
            for (int i = 0; i < 3; i++)
            begin
                plan_vld[i] = (2'(i) < cnt_reg);
            end
            plan_vld[3] = 1'b1;
            cnt_next    = 2'd0;
            exp_next    = 3'd0;
        end
        else
        begin
            case (cnt_reg)
                2'd1:    held_next[1] = data_byte;
                2'd2:    held_next[2] = data_byte;
                default: held_next[0] = data_byte;
            endcase
            cnt_next = cnt_reg + 2'd1;
            if (end_of_text)
            begin
                // truncated sequence at end of text
                for (int i = 0; i < 3; i++)
                begin
                    plan_vld[i] = (2'(i) < cnt_reg);
                    plan_esc[i] = 1'b1;
                end
                plan_vld[3] = 1'b1;
                plan_esc[3] = 1'b1;
                cnt_next    = 2'd0;
                exp_next    = 3'd0;
            end
        end

        if (fresh)
        begin
            if (data_byte < utf8e_pkg::HIGH_BIT)
            begin
                plan_vld[3] = 1'b1;
            end
            else if (len_b == 3'd0 || end_of_text)
            begin
                plan_vld[3] = 1'b1;
                plan_esc[3] = 1'b1;
            end
            else
            begin
                held_next[0] = data_byte;
                cnt_next     = 2'd1;
                exp_next     = len_b;
            end
        end
    end

    // Current slot: lowest pending one
    logic [1:0] cur;
    logic [7:0] cur_byte;
    logic       cur_esc, slot_done;
    logic [3:0] rest;
    logic [7:0] emit_char;

    always_comb
    begin
        if (slot_vld_reg[0])      cur = 2'd0;
        else if (slot_vld_reg[1]) cur = 2'd1;
        else if (slot_vld_reg[2]) cur = 2'd2;
        else                      cur = 2'd3;
    end

    assign cur_byte  = slot_byte_reg[cur];
    assign cur_esc   = slot_esc_reg[cur];
    assign slot_done = !cur_esc || (digit_reg == utf8e_pkg::DIG_LO);
    assign rest      = slot_vld_reg & ~(4'b0001 << cur);

    always_comb
    begin
        if (!cur_esc)
        begin
            emit_char = cur_byte;
        end
        else
        begin
            case (digit_reg)
                utf8e_pkg::DIG_BSL: emit_char = utf8e_pkg::ESC_CHAR;
                utf8e_pkg::DIG_HI:  emit_char = utf8e_pkg::DIGIT_ZERO + {6'b0, cur_byte[7:6]};
                utf8e_pkg::DIG_MID: emit_char = utf8e_pkg::DIGIT_ZERO + {5'b0, cur_byte[5:3]};
                default:            emit_char = utf8e_pkg::DIGIT_ZERO + {5'b0, cur_byte[2:0]};
            endcase
        end
    end

    assign status.pending    = |slot_vld_reg;
    assign status.final_byte = slot_done && (rest == 4'b0);
    assign status.out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        slot_vld_next = slot_vld_reg;
        digit_next    = digit_reg;
        if (cmd.load)
        begin
            slot_vld_next = plan_vld;
            digit_next    = utf8e_pkg::DIG_BSL;
        end
        else if (cmd.emit)
        begin
            if (slot_done)
            begin
                slot_vld_next = rest;
                digit_next    = utf8e_pkg::DIG_BSL;
            end
            else
            begin
                digit_next = digit_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '{default: 8'h00};
            cnt_reg       <= 2'd0;
            exp_reg       <= 3'd0;
            slot_vld_reg  <= 4'b0;
            digit_reg     <= utf8e_pkg::DIG_BSL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_vld_reg <= slot_vld_next;
            digit_reg    <= digit_next;
            if (cmd.load)
            begin
                held_reg <= held_next;
                cnt_reg  <= cnt_next;
                exp_reg  <= exp_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            slot_byte_reg[0] <= held_reg[0];
            slot_byte_reg[1] <= held_reg[1];
            slot_byte_reg[2] <= held_reg[2];
            slot_byte_reg[3] <= data_byte;
            slot_esc_reg     <= plan_esc;
            last_reg         <= end_of_text;
        end
        if (cmd.emit)
        begin
            out_char_reg  <= emit_char;
            run_last_reg  <= status.final_byte;
            text_last_reg <= status.final_byte && last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign run_last  = run_last_reg;
    assign text_last = text_last_reg;

    a_no_load_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !status.pending)
        else $error("load while plan outstanding");

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (status.pending && status.out_free))
        else $error("emit without pending byte or free output");

    a_held_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        ((cnt_reg == 2'd0) == (exp_reg == 3'd0)) &&
        ((cnt_reg == 2'd0) || ({1'b0, cnt_reg} < exp_reg)))
        else $error("held count and expected length disagree");

    a_text_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && text_last_reg) |-> run_last_reg)
        else $error("text_last without run_last");

endmodule

@@ rtl/utf8_invalid_byte_escaper.sv @@
`timescale 1ns / 1ps
// Flow: an input transfer loads the emission plan; each emit then registers one
//   output byte into the output register, which raises out_valid.
// Throughput: one output byte per cycle while out_stall allows; an item costs the
//   load plus one emit per output byte, of which it has 0..16 (escapes cost 4 bytes
//   each). An item that produces nothing still passes through the emit state.
// Reset: rst_n asynchronous, active low; clears held sequence and output valid.

module utf8_invalid_byte_escaper
(
    input  logic       clk,
    input  logic       rst_n,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       end_of_text,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       run_last,
    output logic       text_last
);

    // The controller takes one input transfer, then steps the datapath through
    // the emission plan built for it: held bytes first, then the new byte, each
    // either passed raw or expanded to a backslash and three octal digits.
    utf8e_pkg::cmd_t    cmd;
    utf8e_pkg::status_t status;

    utf8e_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: lead/continuation checks, held-byte registers, plan slots,
    // escape digit sequencer and the output register.
    utf8e_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .end_of_text (end_of_text),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .text_last   (text_last)
    );

endmodule
